>>> sv/euler_to_quaternion_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the Euler angle to quaternion unit.
// ---------------------------------------------------------------------------
`ifndef EULER_TO_QUATERNION_UNIT_ASSERT_SVH
`define EULER_TO_QUATERNION_UNIT_ASSERT_SVH

// Implication checked in the same cycle, disabled during reset.
`define ETQ_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the next cycle, disabled during reset.
`define ETQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// Implication checked in the next cycle, active during reset as well.
`define ETQ_ASSERT_RESET(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/etq_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// etq_pkg
// Constants and the arctangent table of the half-angle CORDIC.
// ---------------------------------------------------------------------------
package etq_pkg;

    // Rotation steps of the CORDIC.
    localparam int CORDIC_STEPS = 24;
    // Width of the CORDIC x, y and angle datapath (Q.30 with headroom).
    localparam int CW = 33;

    typedef logic signed [CW-1:0] t_cword;

    localparam t_cword Q30_PI      = 33'sd3373259426;
    localparam t_cword Q30_HALF_PI = 33'sd1686629713;
    localparam t_cword CORDIC_GAIN = 33'sd652032874;

    // atan(2^-i) in Q.30.
    function automatic t_cword atan_q30(input int i);
        t_cword v;
        v = '0;
        case (i)
            0:  v = 33'sd843314857;
            1:  v = 33'sd497837829;
            2:  v = 33'sd263043837;
            3:  v = 33'sd133525159;
            4:  v = 33'sd67021687;
            5:  v = 33'sd33543516;
            6:  v = 33'sd16775851;
            7:  v = 33'sd8388437;
            8:  v = 33'sd4194283;
            9:  v = 33'sd2097149;
            10: v = 33'sd1048576;
            11: v = 33'sd524288;
            12: v = 33'sd262144;
            13: v = 33'sd131072;
            14: v = 33'sd65536;
            15: v = 33'sd32768;
            16: v = 33'sd16384;
            17: v = 33'sd8192;
            18: v = 33'sd4096;
            19: v = 33'sd2048;
            20: v = 33'sd1024;
            21: v = 33'sd512;
            22: v = 33'sd256;
            23: v = 33'sd128;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> sv/euler_to_quaternion_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// euler_to_quaternion_unit
// Converts roll, pitch and yaw angles into a rotation quaternion.
// ---------------------------------------------------------------------------
// Usage:
// Angles enter on the s_axis stream (roll, pitch, yaw, signed Q3.13 radians);
// the quaternion leaves on the m_axis stream (x, y, z, w, signed Q1.14).
// Each input transfer gives exactly one output transfer, in order.
// Data passes from input transfer to output valid through 29
// register stages: one folding stage, 24 CORDIC stages (one rotation step
// each, three axes side by side), a sign stage, two multiplier stages and a
// rounding and saturation stage.
// Throughput is one item per cycle while m_axis_tready is high; the 24 CORDIC steps set the depth.
// Every stage holds a valid bit and advances whenever it is empty or the
// stage after it advances, so bubbles are squeezed out and a stalled
// receiver only stops the stages that hold data.
// A synchronous low reset clears all valid bits; no payload is cleared.
// When m_axis_tready stays low, the output holds its data and the pipeline
// keeps accepting until every stage is full.
// ---------------------------------------------------------------------------
`include "euler_to_quaternion_unit_assert.svh"

module euler_to_quaternion_unit #(
    parameter int ANGLE_BITS = 16,
    parameter int QUAT_BITS  = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // tdata: roll_angle, pitch_angle, yaw_angle (lowest bits first)
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [((3*ANGLE_BITS+7)/8)*8-1:0]     s_axis_tdata,
    // tdata: quat_x, quat_y, quat_z, quat_w (lowest bits first)
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [((4*QUAT_BITS+7)/8)*8-1:0]      m_axis_tdata
);
    import etq_pkg::*;

    localparam int ASH    = 32 - ANGLE_BITS;
    localparam int PW     = 2*CW + 1;
    localparam int OSH    = 62 - QUAT_BITS;
    // Stage numbers.
    localparam int ST_NEG = CORDIC_STEPS + 1;
    localparam int ST_PR  = CORDIC_STEPS + 2;
    localparam int ST_TR  = CORDIC_STEPS + 3;
    localparam int ST_OUT = CORDIC_STEPS + 4;
    localparam int NST    = CORDIC_STEPS + 5;

    localparam logic signed [PW-1:0] RND_OUT = PW'(64'sd1 <<< (OSH-1));
    localparam logic signed [PW-1:0] Q_HI    = PW'((64'sd1 <<< (QUAT_BITS-1)) - 64'sd1);
    localparam logic signed [PW-1:0] Q_LO    = -PW'(64'sd1 <<< (QUAT_BITS-1));
    localparam logic signed [2*CW-1:0] RND_30 = (2*CW)'(64'sd1 <<< 29);

    // Valid bits and per-stage advance enables.
    logic [NST-1:0] r_v;
    logic [NST:0]   w_en;

    always_comb begin
        w_en[NST] = m_axis_tready;
        for (int k = NST-1; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign s_axis_tready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NST; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // CORDIC state per stage and axis.
    t_cword r_cx  [0:CORDIC_STEPS][0:2];
    t_cword r_cy  [0:CORDIC_STEPS][0:2];
    t_cword r_cz  [0:CORDIC_STEPS][0:2];
    logic   r_neg [0:CORDIC_STEPS][0:2];

    // Stage 0: half the angle and fold it into [-pi/2, pi/2].
    for (genvar a = 0; a < 3; a++) begin : g_fold
        logic signed [ANGLE_BITS-1:0] w_raw;
        t_cword                       w_z;
        assign w_raw = s_axis_tdata[a*ANGLE_BITS +: ANGLE_BITS];
        assign w_z   = CW'(w_raw) <<< ASH;

        always_ff @(posedge i_clk) begin
            if (w_en[0]) begin
                r_cx[0][a] <= CORDIC_GAIN;
                r_cy[0][a] <= '0;
                if (w_z > Q30_HALF_PI) begin
                    r_cz[0][a]  <= w_z - Q30_PI;
                    r_neg[0][a] <= 1'b1;
                end else if (w_z < -Q30_HALF_PI) begin
                    r_cz[0][a]  <= w_z + Q30_PI;
                    r_neg[0][a] <= 1'b1;
                end else begin
                    r_cz[0][a]  <= w_z;
                    r_neg[0][a] <= 1'b0;
                end
            end
        end
    end

    // Stages 1 to 24: one rotation step each.
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        for (genvar a = 0; a < 3; a++) begin : g_axis
            t_cword w_dx, w_dy;
            assign w_dx = r_cy[i][a] >>> i;
            assign w_dy = r_cx[i][a] >>> i;

            always_ff @(posedge i_clk) begin
                if (w_en[i+1]) begin
                    r_neg[i+1][a] <= r_neg[i][a];
                    if (!r_cz[i][a][CW-1]) begin
                        r_cx[i+1][a] <= r_cx[i][a] - w_dx;
                        r_cy[i+1][a] <= r_cy[i][a] + w_dy;
                        r_cz[i+1][a] <= r_cz[i][a] - atan_q30(i);
                    end else begin
                        r_cx[i+1][a] <= r_cx[i][a] + w_dx;
                        r_cy[i+1][a] <= r_cy[i][a] - w_dy;
                        r_cz[i+1][a] <= r_cz[i][a] + atan_q30(i);
                    end
                end
            end
        end
    end

    // Sign stage: undo the fold. Index 0 roll, 1 pitch, 2 yaw.
    t_cword r_sin [0:2];
    t_cword r_cos [0:2];

    always_ff @(posedge i_clk) begin
        if (w_en[ST_NEG]) begin
            for (int a = 0; a < 3; a++) begin
                r_sin[a] <= r_neg[CORDIC_STEPS][a] ? -r_cy[CORDIC_STEPS][a]
                                                   :  r_cy[CORDIC_STEPS][a];
                r_cos[a] <= r_neg[CORDIC_STEPS][a] ? -r_cx[CORDIC_STEPS][a]
                                                   :  r_cx[CORDIC_STEPS][a];
            end
        end
    end

    // Pair products of pitch and roll terms, rounded back to Q.30.
    logic signed [2*CW-1:0] w_p_cysx, w_p_sycx, w_p_cycx, w_p_sysx;
    t_cword r_cysx, r_sycx, r_cycx, r_sysx;
    t_cword r_sz, r_cz3;

    assign w_p_cysx = r_cos[1] * r_sin[0] + RND_30;
    assign w_p_sycx = r_sin[1] * r_cos[0] + RND_30;
    assign w_p_cycx = r_cos[1] * r_cos[0] + RND_30;
    assign w_p_sysx = r_sin[1] * r_sin[0] + RND_30;

    always_ff @(posedge i_clk) begin
        if (w_en[ST_PR]) begin
            r_cysx <= CW'(w_p_cysx >>> 30);
            r_sycx <= CW'(w_p_sycx >>> 30);
            r_cycx <= CW'(w_p_cycx >>> 30);
            r_sysx <= CW'(w_p_sysx >>> 30);
            r_sz   <= r_sin[2];
            r_cz3  <= r_cos[2];
        end
    end

    // Products with the yaw terms, kept in Q.60.
    logic signed [2*CW-1:0] r_t [0:7];

    always_ff @(posedge i_clk) begin
        if (w_en[ST_TR]) begin
            r_t[0] <= r_cysx * r_cz3;
            r_t[1] <= r_sycx * r_sz;
            r_t[2] <= r_sycx * r_cz3;
            r_t[3] <= r_cysx * r_sz;
            r_t[4] <= r_cycx * r_sz;
            r_t[5] <= r_sysx * r_cz3;
            r_t[6] <= r_cycx * r_cz3;
            r_t[7] <= r_sysx * r_sz;
        end
    end

    // Final sums, round half up and saturate.
    logic signed [PW-1:0] w_sum [0:3];
    logic signed [PW-1:0] w_rnd [0:3];
    logic [QUAT_BITS-1:0] w_q   [0:3];
    logic [QUAT_BITS-1:0] r_q   [0:3];

    always_comb begin
        w_sum[0] = PW'(r_t[0]) + PW'(r_t[1]);
        w_sum[1] = PW'(r_t[2]) - PW'(r_t[3]);
        w_sum[2] = PW'(r_t[4]) - PW'(r_t[5]);
        w_sum[3] = PW'(r_t[6]) + PW'(r_t[7]);
        for (int c = 0; c < 4; c++) begin
            w_rnd[c] = (w_sum[c] + RND_OUT) >>> OSH;
            if (w_rnd[c] > Q_HI) begin
                w_q[c] = QUAT_BITS'(Q_HI);
            end else if (w_rnd[c] < Q_LO) begin
                w_q[c] = QUAT_BITS'(Q_LO);
            end else begin
                w_q[c] = QUAT_BITS'(w_rnd[c]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_OUT]) begin
            for (int c = 0; c < 4; c++) begin
                r_q[c] <= w_q[c];
            end
        end
    end

    // Output packing.
    assign m_axis_tvalid = r_v[ST_OUT];

    always_comb begin
        m_axis_tdata = '0;
        for (int c = 0; c < 4; c++) begin
            m_axis_tdata[c*QUAT_BITS +: QUAT_BITS] = r_q[c];
        end
    end

    // Assertions.
    `ETQ_ASSERT_RESET(a_reset_clears, i_clk, !i_rst_n, !m_axis_tvalid && r_v == '0,
        "pipeline not empty after reset")
    `ETQ_ASSERT_SAME(a_empty_accepts, i_clk, i_rst_n, !r_v[0], s_axis_tready,
        "empty input stage refuses a transfer")
    `ETQ_ASSERT_NEXT(a_stage_holds, i_clk, i_rst_n, r_v[CORDIC_STEPS] && !w_en[CORDIC_STEPS],
        r_v[CORDIC_STEPS] && $stable(r_cx[CORDIC_STEPS][0]),
        "stalled CORDIC stage lost its item")
    `ETQ_ASSERT_NEXT(a_out_fill, i_clk, i_rst_n, r_v[ST_TR] && w_en[ST_OUT],
        m_axis_tvalid, "item lost before the output register")

endmodule

>>> tb/sv/euler_to_quaternion_unit_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// euler_to_quaternion_unit_checker
// Watches both streams of the Euler angle to quaternion unit, computes the
// expected quaternion of every accepted angle triple and compares the
// outputs in order, field by field.
// ---------------------------------------------------------------------------
module euler_to_quaternion_unit_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    // tdata: roll_angle, pitch_angle, yaw_angle (lowest bits first)
    input  logic [47:0] i_s_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    // tdata: quat_x, quat_y, quat_z, quat_w (lowest bits first)
    input  logic [63:0] i_m_tdata,
    output int          o_errors,
    output int          o_pending
);

    localparam int QBITS = 16;
    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint GAIN_Q30    = 64'sd652032874;

    typedef struct packed {
        logic [15:0] w;
        logic [15:0] z;
        logic [15:0] y;
        logic [15:0] x;
    } t_quat;

    t_quat quat_queue[$];

    int errors = 0;
    assign o_errors  = errors;
    assign o_pending = quat_queue.size();

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    // Sine and cosine of half an angle by the folded rotation CORDIC.
    task automatic half_sin_cos(input logic [15:0] raw, output longint s,
                                output longint c);
        longint ang, cx, cy, dx, dy;
        bit flip;
        ang = longint'($signed(raw)) * 65536;
        cx = GAIN_Q30;
        cy = 0;
        flip = 0;
        if (ang > HALF_PI_Q30) begin
            ang -= PI_Q30;
            flip = 1;
        end else if (ang < -HALF_PI_Q30) begin
            ang += PI_Q30;
            flip = 1;
        end
        for (int i = 0; i < etq_pkg::CORDIC_STEPS; i++) begin
            dx = floor_shift(cy, i);
            dy = floor_shift(cx, i);
            if (ang >= 0) begin
                cx -= dx;
                cy += dy;
                ang -= longint'(etq_pkg::atan_q30(i));
            end else begin
                cx += dx;
                cy -= dy;
                ang += longint'(etq_pkg::atan_q30(i));
            end
        end
        if (flip) begin
            cx = -cx;
            cy = -cy;
        end
        s = cy;
        c = cx;
    endtask

    function automatic longint mul_round(longint a, longint b);
        return floor_shift(a * b + (64'sd1 << 29), 30);
    endfunction

    function automatic logic [15:0] round_sat(longint q60);
        longint v;
        v = floor_shift(q60 + (64'sd1 << (61 - QBITS)), 62 - QBITS);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    task automatic predict_quat(input logic [47:0] angles);
        longint sx, cx, sy, cy, sz, cz, cysx, sycx, cycx, sysx;
        t_quat q;
        half_sin_cos(angles[15:0], sx, cx);
        half_sin_cos(angles[31:16], sy, cy);
        half_sin_cos(angles[47:32], sz, cz);
        cysx = mul_round(cy, sx);
        sycx = mul_round(sy, cx);
        cycx = mul_round(cy, cx);
        sysx = mul_round(sy, sx);
        q.x = round_sat(cysx * cz + sycx * sz);
        q.y = round_sat(sycx * cz - cysx * sz);
        q.z = round_sat(cycx * sz - sysx * cz);
        q.w = round_sat(cycx * cz + sysx * sz);
        quat_queue.push_back(q);
    endtask

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
        errors++;
    endtask

    // Predict on each input transfer and compare on each output transfer.
    always @(posedge i_clk) begin
        t_quat got, want;
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready) predict_quat(i_s_tdata);
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata;
                if (quat_queue.size() == 0) begin
                    $display("unexpected output at %0t: %h", $time, i_m_tdata);
                    errors++;
                end else begin
                    want = quat_queue.pop_front();
                    if (got.x !== want.x) report_mismatch("quat_x", got.x, want.x);
                    if (got.y !== want.y) report_mismatch("quat_y", got.y, want.y);
                    if (got.z !== want.z) report_mismatch("quat_z", got.z, want.z);
                    if (got.w !== want.w) report_mismatch("quat_w", got.w, want.w);
                end
            end
        end
    end

endmodule

>>> tb/sv/euler_to_quaternion_unit_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// euler_to_quaternion_unit_test
// Drives angle triples into the unit, with directed extremes first and then
// random angles, under random gaps on both streams and one long output stall.
// ---------------------------------------------------------------------------
module euler_to_quaternion_unit_test;

    localparam int WATCH_LIMIT = 5000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    // tdata: roll_angle, pitch_angle, yaw_angle (lowest bits first)
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    // tdata: quat_x, quat_y, quat_z, quat_w (lowest bits first)
    logic [63:0] m_tdata;
    int          errors;
    int          pending;
    bit          hold_off = 0;
    int          quiet = 0;

    euler_to_quaternion_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready),
        .s_axis_tdata(s_tdata),
        .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready),
        .m_axis_tdata(m_tdata)
    );

    euler_to_quaternion_unit_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: random stalls, a calm stretch and one long hold-off.
    initial begin
        m_tready = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off) m_tready <= 0;
            else if ($time > 3000 && $time < 5000) m_tready <= 1;
            else m_tready <= ($urandom_range(99) >= 16);
        end
    end

    // Long receiver hold-off, counted here, while the sender keeps offering.
    initial begin
        wait (i_rst_n);
        repeat (400) @(posedge i_clk);
        hold_off = 1;
        repeat (200) @(posedge i_clk);
        hold_off = 0;
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= WATCH_LIMIT) begin
            $display("euler_to_quaternion_unit_test: FAIL");
            $finish;
        end
    end

    task automatic send_angles(input logic [15:0] r, input logic [15:0] p,
                               input logic [15:0] y, input bit calm);
        if (!calm) begin
            while ($urandom_range(99) < 16) begin
                s_tvalid <= 0;
                @(posedge i_clk);
            end
        end
        s_tvalid <= 1;
        s_tdata  <= {y, p, r};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_angle();
        case ($urandom_range(3))
            0: return 16'h8000 + 16'($urandom_range(63));
            1: return 16'h7fff - 16'($urandom_range(63));
            2: return 16'($urandom_range(25736) - 12868);
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic [15:0] edge_vals[8] = '{16'h0000, 16'h7fff, 16'h8000, 16'h0001,
                                     16'hffff, 16'd12868, 16'hcdbc, 16'd25736};
        i_rst_n  = 0;
        s_tvalid = 0;
        s_tdata  = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // Directed: extremes, the pi folding boundaries and zero.
        for (int k = 0; k < 8; k++)
            send_angles(edge_vals[k], edge_vals[(k + 3) % 8], edge_vals[(k + 5) % 8], 0);
        send_angles(16'h7fff, 16'h7fff, 16'h7fff, 0);
        send_angles(16'h8000, 16'h8000, 16'h8000, 0);
        send_angles(16'h8000, 16'h7fff, 16'h0000, 0);
        send_angles(16'h5555, 16'haaaa, 16'h3333, 0);
        for (int k = 0; k < 800; k++)
            send_angles(pick_angle(), pick_angle(), pick_angle(), (k >= 300 && k < 400));
        s_tvalid <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (errors == 0) $display("euler_to_quaternion_unit_test: PASS");
        else $display("euler_to_quaternion_unit_test: FAIL");
        $finish;
    end

endmodule

>>> files.f
+incdir+sv
sv/etq_pkg.sv
sv/euler_to_quaternion_unit.sv
tb/sv/euler_to_quaternion_unit_checker.sv
tb/sv/euler_to_quaternion_unit_test.sv
